>>> hw/rtl/hld_pkg.sv
`timescale 1ns / 1ps

package hld_pkg;

    localparam logic [1:0] MODE_LEN_ONLY  = 2'd0;
    localparam logic [1:0] MODE_ID_LEN    = 2'd1;
    localparam logic [1:0] MODE_TYPE_LEN  = 2'd2;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    localparam logic [1:0] KIND_BODY      = 2'd0;
    localparam logic [1:0] KIND_EMPTY     = 2'd1;
    localparam logic [1:0] KIND_ERROR     = 2'd2;

    localparam logic [1:0] ERR_LEN_INVALID = 2'd0;
    localparam logic [1:0] ERR_TOO_LARGE   = 2'd1;
    localparam logic [1:0] ERR_ID_OVERFLOW = 2'd2;

    localparam logic [2:0] REG_FRAMING_MODE   = 3'd0;
    localparam logic [2:0] REG_ID_WIDTH_CODE  = 3'd1;
    localparam logic [2:0] REG_LEN_WIDTH_CODE = 3'd2;
    localparam logic [2:0] REG_BIG_ENDIAN     = 3'd3;
    localparam logic [2:0] REG_LEN_COUNTS_HDR = 3'd4;
    localparam logic [2:0] REG_MAX_BODY_SIZE  = 3'd5;

    typedef struct packed {
        logic [1:0]  framing_mode;
        logic [2:0]  id_width_code;
        logic [2:0]  len_width_code;
        logic        big_endian;
        logic        length_counts_header;
        logic [31:0] max_body_size;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  body_byte;
        logic        frame_first;
        logic        frame_last;
        logic [31:0] frame_id;
        logic [15:0] frame_kind;
        logic [1:0]  error_code;
    } t_rec;

endpackage

>>> hw/rtl/header_length_deframer.sv
`timescale 1ns / 1ps
// Channel   Handshake                   Payload
// input     i_valid / o_ready           i_data_byte, i_chunk_end
// result    o_valid / i_ready           o_result_kind, o_body_byte, o_frame_first,
//                                       o_frame_last, o_frame_id, o_frame_kind,
//                                       o_error_code
// config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One byte per cycle. The parser handles each byte in the cycle it is taken and
// places any result in a DEPTH-entry queue; the queue holds it from the next cycle.
// Outside reset, o_ready drops only while the queue is full. Synchronous active-low
// reset holds o_ready and o_cfg_ready low. Config writes complete at once.

module header_length_deframer #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_chunk_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_body_byte,
    output logic        o_frame_first,
    output logic        o_frame_last,
    output logic [31:0] o_frame_id,
    output logic [15:0] o_frame_kind,
    output logic [1:0]  o_error_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import hld_pkg::*;

    t_cfg r_cfg;
    t_rec front_rec, head_rec;
    logic push, full;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAMING_MODE:   r_cfg.framing_mode         <= i_cfg_data[1:0];
                REG_ID_WIDTH_CODE:  r_cfg.id_width_code        <= i_cfg_data[2:0];
                REG_LEN_WIDTH_CODE: r_cfg.len_width_code       <= i_cfg_data[2:0];
                REG_BIG_ENDIAN:     r_cfg.big_endian           <= i_cfg_data[0];
                REG_LEN_COUNTS_HDR: r_cfg.length_counts_header <= i_cfg_data[0];
                REG_MAX_BODY_SIZE:  r_cfg.max_body_size        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_chunk_end (i_chunk_end),
        .i_full      (full),
        .o_push      (push),
        .o_rec       (front_rec)
    );

    hld_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rec   (head_rec)
    );

    assign o_result_kind = head_rec.result_kind;
    assign o_body_byte   = head_rec.body_byte;
    assign o_frame_first = head_rec.frame_first;
    assign o_frame_last  = head_rec.frame_last;
    assign o_frame_id    = head_rec.frame_id;
    assign o_frame_kind  = head_rec.frame_kind;
    assign o_error_code  = head_rec.error_code;

endmodule

>>> hw/rtl/hld_front.sv
`timescale 1ns / 1ps

module hld_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hld_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_chunk_end,
    input  logic          i_full,
    output logic          o_push,
    output hld_pkg::t_rec o_rec
);
    import hld_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_DISCARD
    } t_phase;

    function automatic logic [3:0] code_width(input logic [2:0] code,
                                              input logic [3:0] dflt);
        case (code)
            3'd0:    return dflt;
            3'd1:    return 4'd1;
            3'd2:    return 4'd2;
            3'd3:    return 4'd4;
            default: return 4'd8;
        endcase
    endfunction

    t_phase      r_phase, n_phase;
    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic [63:0] r_id, n_id;
    logic [63:0] r_len, n_len;
    logic [63:0] r_rem, n_rem;
    logic        r_started, n_started;

    logic        accept;
    logic [1:0]  mode;
    logic [3:0]  idw;
    logic [3:0]  lw;
    logic [4:0]  hs;
    logic        in_id;
    logic [3:0]  pos;
    logic [63:0] id_base, len_base, fld_base, fld_new;
    logic [63:0] id_new, len_new;
    logic        hdr_done;
    logic        id_ovf, err_len, err_big, body_zero;
    logic [32:0] cmp_ref;
    logic [63:0] body;

    assign o_ready = i_rst_n && !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        mode = (i_cfg.framing_mode == MODE_UNUSED) ? MODE_LEN_ONLY : i_cfg.framing_mode;
        idw  = (mode == MODE_LEN_ONLY) ? 4'd0 :
               code_width(i_cfg.id_width_code, (mode == MODE_ID_LEN) ? 4'd2 : 4'd1);
        lw   = code_width(i_cfg.len_width_code, (mode == MODE_ID_LEN) ? 4'd2 : 4'd4);
        hs   = {1'b0, idw} + {1'b0, lw};

        id_base  = (r_hdr_cnt == 4'd0) ? 64'd0 : r_id;
        len_base = (r_hdr_cnt == 4'd0) ? 64'd0 : r_len;
        in_id    = {1'b0, r_hdr_cnt} < {1'b0, idw};
        pos      = in_id ? r_hdr_cnt : r_hdr_cnt - idw;
        fld_base = in_id ? id_base : len_base;
        if (i_cfg.big_endian) begin
            fld_new = {fld_base[55:0], i_data_byte};
        end else if (!pos[3]) begin
            fld_new = fld_base | ({56'd0, i_data_byte} << {pos[2:0], 3'b000});
        end else begin
            fld_new = fld_base;
        end
        id_new  = in_id ? fld_new : id_base;
        len_new = in_id ? len_base : fld_new;

        hdr_done = !(({1'b0, r_hdr_cnt} + 5'd1) < hs);

        // header checks, all against the updated accumulators
        id_ovf = (mode != MODE_LEN_ONLY) && (id_new[63:32] != 32'd0);
        if (i_cfg.length_counts_header) begin
            err_len   = (len_new[63:5] == 59'd0) && (len_new[4:0] < hs);
            body_zero = (len_new[63:5] == 59'd0) && (len_new[4:0] == hs);
            cmp_ref   = {1'b0, i_cfg.max_body_size} + {28'd0, hs};
            body      = len_new - {59'd0, hs};
        end else begin
            err_len   = (&len_new[63:5]) && (len_new[4:0] > ~hs);
            body_zero = (len_new == 64'd0);
            cmp_ref   = {1'b0, i_cfg.max_body_size};
            body      = len_new;
        end
        err_big = (i_cfg.max_body_size != 32'd0) &&
                  ((len_new[63:33] != 31'd0) || (len_new[32:0] > cmp_ref));
    end

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_id      = r_id;
        n_len     = r_len;
        n_rem     = r_rem;
        n_started = r_started;
        o_push    = 1'b0;
        o_rec     = '0;

        if (accept) begin
            case (r_phase)
                PH_DISCARD: begin
                    if (i_chunk_end) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_BODY: begin
                    o_push            = 1'b1;
                    o_rec.result_kind = KIND_BODY;
                    o_rec.body_byte   = i_data_byte;
                    o_rec.frame_first = !r_started;
                    o_rec.frame_last  = (r_rem[63:1] == 63'd0);
                    o_rec.frame_id    = (mode == MODE_LEN_ONLY) ? 32'd0 : r_id[31:0];
                    o_rec.frame_kind  = (mode == MODE_TYPE_LEN) ? r_id[15:0] : 16'd0;
                    n_started         = 1'b1;
                    n_rem             = (r_rem == 64'd0) ? 64'd0 : r_rem - 64'd1;
                    if (r_rem[63:1] == 63'd0) begin
                        n_phase   = PH_HEADER;
                        n_started = 1'b0;
                    end
                end
                PH_HEADER: begin
                    n_id  = id_new;
                    n_len = len_new;
                    if (!hdr_done) begin
                        n_hdr_cnt = r_hdr_cnt + 4'd1;
                    end else begin
                        n_hdr_cnt = 4'd0;
                        if (id_ovf || err_len || err_big) begin
                            o_push            = 1'b1;
                            o_rec.result_kind = KIND_ERROR;
                            o_rec.error_code  = id_ovf  ? ERR_ID_OVERFLOW :
                                                err_len ? ERR_LEN_INVALID : ERR_TOO_LARGE;
                            n_phase           = i_chunk_end ? PH_HEADER : PH_DISCARD;
                            n_started         = 1'b0;
                            n_rem             = 64'd0;
                        end else if (body_zero) begin
                            o_push            = 1'b1;
                            o_rec.result_kind = KIND_EMPTY;
                            o_rec.frame_last  = 1'b1;
                            o_rec.frame_id    = (mode == MODE_LEN_ONLY) ? 32'd0 : id_new[31:0];
                            o_rec.frame_kind  = (mode == MODE_TYPE_LEN) ? id_new[15:0] : 16'd0;
                            n_phase           = PH_HEADER;
                        end else begin
                            n_rem     = body;
                            n_started = 1'b0;
                            n_phase   = PH_BODY;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= 4'd0;
            r_started <= 1'b0;
            r_rem     <= 64'd0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_started <= n_started;
            r_rem     <= n_rem;
        end
        r_id  <= n_id;
        r_len <= n_len;
    end

endmodule

>>> hw/rtl/hld_queue.sv
`timescale 1ns / 1ps

module hld_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hld_pkg::t_rec i_rec,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_ready,
    output hld_pkg::t_rec o_rec
);
    import hld_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    t_rec             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_rec   = r_slot[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_rec;
        end
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hld_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned QUIET_CYCLES = 3;
    localparam int unsigned TAIL_CYCLES  = 10;

    localparam logic [2:0] REG_SPARE  = 3'd7;

    localparam logic [2:0] WC_DEFAULT = 3'd0;
    localparam logic [2:0] WC_1B      = 3'd1;
    localparam logic [2:0] WC_2B      = 3'd2;
    localparam logic [2:0] WC_4B      = 3'd3;
    localparam logic [2:0] WC_8B      = 3'd4;

    typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_DISCARD} t_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_chunk_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_body_byte;
    logic        o_frame_first;
    logic        o_frame_last;
    logic [31:0] o_frame_id;
    logic [15:0] o_frame_kind;
    logic [1:0]  o_error_code;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    header_length_deframer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_chunk_end   (i_chunk_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_body_byte   (o_body_byte),
        .o_frame_first (o_frame_first),
        .o_frame_last  (o_frame_last),
        .o_frame_id    (o_frame_id),
        .o_frame_kind  (o_frame_kind),
        .o_error_code  (o_error_code),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // deframer shadow state
    t_cfg        live_cfg = '0;
    t_phase      ph = PH_HEADER;
    logic [3:0]  hdr_cnt = '0;
    logic [63:0] id_acc = '0;
    logic [63:0] len_acc = '0;
    logic [63:0] body_left = '0;
    logic        body_seen = 1'b0;

    t_rec        parsed_q[$];
    int unsigned fails = 0;
    int unsigned cycles = 0;
    int unsigned bytes_sent = 0;
    int unsigned tx_idle_pct = 18;
    int unsigned rx_idle_pct = 71;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("header_length_deframer: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic logic [1:0] live_mode();
        return (live_cfg.framing_mode == MODE_UNUSED) ? MODE_LEN_ONLY : live_cfg.framing_mode;
    endfunction

    function automatic int unsigned code_bytes(logic [2:0] code, int unsigned dflt);
        case (code)
            WC_DEFAULT: return dflt;
            WC_1B:      return 1;
            WC_2B:      return 2;
            WC_4B:      return 4;
            default:    return 8;
        endcase
    endfunction

    function automatic int unsigned id_bytes();
        if (live_mode() == MODE_LEN_ONLY) return 0;
        return code_bytes(live_cfg.id_width_code, (live_mode() == MODE_ID_LEN) ? 2 : 1);
    endfunction

    function automatic int unsigned len_bytes();
        return code_bytes(live_cfg.len_width_code, (live_mode() == MODE_ID_LEN) ? 2 : 4);
    endfunction

    function automatic logic [63:0] fold_byte(logic [63:0] acc, logic [7:0] b, int unsigned pos);
        if (live_cfg.big_endian) return {acc[55:0], b};
        if (pos < 8) return acc | (64'(b) << (8 * pos));
        return acc;
    endfunction

    function automatic void stamp_ids(inout t_rec r);
        r.frame_id   = (live_mode() == MODE_LEN_ONLY) ? 32'd0 : id_acc[31:0];
        r.frame_kind = (live_mode() == MODE_TYPE_LEN) ? id_acc[15:0] : 16'd0;
    endfunction

    // one input byte through the deframer; returns 1 when it yields a record
    function automatic bit parse_byte(input logic [7:0] b, input logic ce, output t_rec r);
        int unsigned idw;
        int unsigned hs;
        int unsigned c;
        logic [63:0] body;
        logic [1:0]  code;
        bit          bad;
        r = '0;
        if (ph == PH_DISCARD) begin
            if (ce) ph = PH_HEADER;
            return 0;
        end
        if (ph == PH_BODY) begin
            r.result_kind = KIND_BODY;
            r.body_byte   = b;
            r.frame_first = !body_seen;
            r.frame_last  = (body_left <= 64'd1);
            stamp_ids(r);
            body_seen = 1'b1;
            if (body_left != 0) body_left = body_left - 1;
            if (body_left == 0) begin
                ph = PH_HEADER;
                body_seen = 1'b0;
            end
            return 1;
        end
        idw = id_bytes();
        hs  = idw + len_bytes();
        c   = hdr_cnt;
        if (c == 0) begin
            id_acc  = '0;
            len_acc = '0;
        end
        if (c < idw) id_acc = fold_byte(id_acc, b, c);
        else len_acc = fold_byte(len_acc, b, c - idw);
        if (c + 1 < hs) begin
            hdr_cnt = 4'(c + 1);
            return 0;
        end
        hdr_cnt = '0;
        bad  = 1'b0;
        code = ERR_LEN_INVALID;
        body = len_acc;
        if (live_mode() != MODE_LEN_ONLY && id_acc > 64'hFFFF_FFFF) begin
            bad  = 1'b1;
            code = ERR_ID_OVERFLOW;
        end else begin
            if (live_cfg.length_counts_header) begin
                if (len_acc < 64'(hs)) bad = 1'b1;
                else body = len_acc - 64'(hs);
            end
            if (!bad && body > ~64'd0 - 64'(hs)) bad = 1'b1;
            if (!bad && live_cfg.max_body_size != 0 && body > {32'd0, live_cfg.max_body_size}) begin
                bad  = 1'b1;
                code = ERR_TOO_LARGE;
            end
        end
        if (bad) begin
            r.result_kind = KIND_ERROR;
            r.error_code  = code;
            ph = ce ? PH_HEADER : PH_DISCARD;
            body_seen = 1'b0;
            body_left = '0;
            return 1;
        end
        stamp_ids(r);
        if (body == 0) begin
            r.result_kind = KIND_EMPTY;
            r.frame_last  = 1'b1;
            ph = PH_HEADER;
            return 1;
        end
        body_left = body;
        body_seen = 1'b0;
        ph = PH_BODY;
        return 0;
    endfunction

    task automatic match_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_rec want;
        if (i_rst_n && o_valid && i_ready) begin
            if (parsed_q.size() == 0) begin
                $display("%0t: result_kind expected none actual %0h", $time, o_result_kind);
                fails++;
            end else begin
                want = parsed_q.pop_front();
                match_field("result_kind", want.result_kind, o_result_kind);
                match_field("body_byte", want.body_byte, o_body_byte);
                match_field("frame_first", want.frame_first, o_frame_first);
                match_field("frame_last", want.frame_last, o_frame_last);
                match_field("frame_id", want.frame_id, o_frame_id);
                match_field("frame_kind", want.frame_kind, o_frame_kind);
                match_field("error_code", want.error_code, o_error_code);
            end
        end
    end

    task automatic push_byte(logic [7:0] b, logic ce);
        t_rec r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_chunk_end <= ce;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        if (parse_byte(b, ce, r)) parsed_q.insert(parsed_q.size(), r);
    endtask

    task automatic await_quiet();
        i_valid <= 1'b0;
        while (parsed_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        await_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FRAMING_MODE:   live_cfg.framing_mode = val[1:0];
            REG_ID_WIDTH_CODE:  live_cfg.id_width_code = val[2:0];
            REG_LEN_WIDTH_CODE: live_cfg.len_width_code = val[2:0];
            REG_BIG_ENDIAN:     live_cfg.big_endian = val[0];
            REG_LEN_COUNTS_HDR: live_cfg.length_counts_header = val[0];
            REG_MAX_BODY_SIZE:  live_cfg.max_body_size = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_field(logic [63:0] v, int unsigned w, logic ce_last);
        for (int unsigned k = 0; k < w; k++)
            push_byte(live_cfg.big_endian ? v[8 * (w - 1 - k) +: 8] : v[8 * k +: 8],
                      (k == w - 1) ? ce_last : ($urandom_range(0, 99) < 10));
    endtask

    // feed bytes until the deframer is back at the start of a header
    task automatic settle_stream();
        while (ph != PH_HEADER || hdr_cnt != 0)
            push_byte(8'($urandom()), $urandom_range(0, 99) < ((ph == PH_DISCARD) ? 30 : 10));
    endtask

    task automatic random_frame();
        int unsigned idw;
        int unsigned lw;
        int unsigned hs;
        int unsigned body_n;
        int unsigned roll;
        logic [63:0] cap;
        logic [63:0] id_v;
        logic [63:0] len_v;
        logic [63:0] big_v;
        idw = id_bytes();
        lw  = len_bytes();
        hs  = idw + lw;
        cap = (lw == 8) ? ~64'd0 : ((64'd1 << (8 * lw)) - 1);
        id_v = 64'($urandom());
        if (idw != 0 && idw < 4) id_v = id_v & ((64'd1 << (8 * idw)) - 1);
        body_n = $urandom_range(0, 12);
        if (live_cfg.max_body_size != 0 && body_n > live_cfg.max_body_size)
            body_n = live_cfg.max_body_size;
        len_v = 64'(body_n) + (live_cfg.length_counts_header ? 64'(hs) : 64'd0);
        roll = $urandom_range(0, 99);
        if (roll < 5 && idw == 8) begin
            id_v[63:32] = $urandom_range(32'hFFFF_FFFF, 1);
        end else if (roll < 10 && live_cfg.length_counts_header) begin
            len_v = 64'($urandom_range(0, hs - 1));
        end else if (roll < 10 && lw == 8) begin
            len_v = ~64'd0 - 64'($urandom_range(0, hs - 1));
        end else if (roll < 16 && live_cfg.max_body_size != 0) begin
            big_v = {32'd0, live_cfg.max_body_size} + 64'($urandom_range(1, 4))
                    + (live_cfg.length_counts_header ? 64'(hs) : 64'd0);
            if (big_v <= cap) len_v = big_v;
        end
        if (idw != 0) send_field(id_v, idw, 1'b0);
        send_field(len_v, lw, $urandom_range(0, 1));
        settle_stream();
    endtask

    task automatic randomize_cfg();
        logic [31:0] cap;
        case ($urandom_range(0, 9))
            0, 1, 2:    cap = '0;
            3, 4, 5, 6: cap = $urandom_range(1, 64);
            7:          cap = 32'hFFFF_FFFF;
            default:    cap = $urandom();
        endcase
        write_reg(REG_FRAMING_MODE, $urandom_range(0, 3));
        write_reg(REG_ID_WIDTH_CODE, $urandom_range(0, 7));
        write_reg(REG_LEN_WIDTH_CODE, $urandom_range(0, 7));
        write_reg(REG_BIG_ENDIAN, $urandom_range(0, 1));
        write_reg(REG_LEN_COUNTS_HDR, $urandom_range(0, 1));
        write_reg(REG_MAX_BODY_SIZE, cap);
    endtask

    task automatic test_reset_defaults();
        send_field(64'd0, 4, 1'b0);
    endtask

    task automatic test_body_bytes();
        write_reg(REG_LEN_WIDTH_CODE, WC_1B);
        send_field(64'd2, 1, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
    endtask

    task automatic test_type_mode();
        write_reg(REG_FRAMING_MODE, MODE_TYPE_LEN);
        write_reg(REG_BIG_ENDIAN, 1'b1);
        send_field(64'hA5, 1, 1'b0);
        send_field(64'd1, 1, 1'b0);
        push_byte(8'h5A, 1'b0);
    endtask

    task automatic test_id_overflow();
        write_reg(REG_FRAMING_MODE, MODE_ID_LEN);
        write_reg(REG_ID_WIDTH_CODE, 3'd5);
        send_field(64'h0000_0001_0000_0000, 8, 1'b0);
        send_field(64'd0, 1, 1'b1);
    endtask

    task automatic test_too_large();
        write_reg(REG_FRAMING_MODE, MODE_LEN_ONLY);
        write_reg(REG_MAX_BODY_SIZE, 32'd3);
        send_field(64'd4, 1, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h11, 1'b1);
    endtask

    task automatic test_len_invalid();
        write_reg(REG_LEN_COUNTS_HDR, 1'b1);
        send_field(64'd0, 1, 1'b1);
        send_field(64'd1, 1, 1'b0);
    endtask

    task automatic test_len_wrap();
        write_reg(REG_LEN_COUNTS_HDR, 1'b0);
        write_reg(REG_LEN_WIDTH_CODE, 3'd7);
        send_field(~64'd0, 8, 1'b1);
    endtask

    task automatic test_unused_mode();
        write_reg(REG_FRAMING_MODE, MODE_UNUSED);
        write_reg(REG_LEN_WIDTH_CODE, WC_1B);
        write_reg(REG_MAX_BODY_SIZE, 32'd0);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_field(64'd1, 1, 1'b0);
        push_byte(8'h3C, 1'b0);
    endtask

    // id field shrinks mid-header: the next length byte lands past byte 7
    task automatic test_live_reconfig();
        write_reg(REG_FRAMING_MODE, MODE_ID_LEN);
        write_reg(REG_ID_WIDTH_CODE, WC_8B);
        write_reg(REG_LEN_WIDTH_CODE, WC_2B);
        write_reg(REG_BIG_ENDIAN, 1'b0);
        send_field(64'h1234_5678, 8, 1'b0);
        push_byte(8'h00, 1'b0);
        write_reg(REG_ID_WIDTH_CODE, WC_1B);
        push_byte(8'hEE, 1'b0);
        write_reg(REG_ID_WIDTH_CODE, WC_4B);
    endtask

    task automatic test_random_traffic(int unsigned tx_pct, int unsigned rx_pct,
                                       int unsigned n_bytes);
        int unsigned goal;
        int unsigned cfg_goal;
        int unsigned roll;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal = bytes_sent + n_bytes;
        while (bytes_sent < goal) begin
            randomize_cfg();
            cfg_goal = bytes_sent + 80;
            while (bytes_sent < cfg_goal && bytes_sent < goal) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    await_quiet();
                end else if (roll < 14 && live_cfg.max_body_size inside {[1:64]}) begin
                    // junk bytes; bodies stay short under a small size cap
                    repeat ($urandom_range(1, 6))
                        push_byte(8'($urandom()), $urandom_range(0, 99) < 20);
                    settle_stream();
                end else begin
                    random_frame();
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_body_bytes();
        test_type_mode();
        test_id_overflow();
        test_too_large();
        test_len_invalid();
        test_len_wrap();
        test_unused_mode();
        test_live_reconfig();

        test_random_traffic(18, 71, 650);
        test_random_traffic(71, 18, 650);
        test_random_traffic(0, 0, 650);

        await_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("header_length_deframer: match");
        end else begin
            $display("header_length_deframer: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/hld_pkg.sv
hw/rtl/hld_front.sv
hw/rtl/hld_queue.sv
hw/rtl/header_length_deframer.sv
verif/tb_top.sv
